>>> hdl/mslp_pkg.sv
// Shared types and constants for the mode select parameter list parser.
`default_nettype none

package mslp_pkg;

    // Parameter list buffer size; the effective list length is clipped to it.
    localparam logic [15:0] BUFFER_BYTES = 16'd256;

    // Depth of the result queue in front of the output channel.
    localparam int QDEPTH = 4;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int QIDX_W = $clog2(QDEPTH);

    // Result kinds.
    localparam logic [1:0] KIND_DESC   = 2'd0;
    localparam logic [1:0] KIND_PHDR   = 2'd1;
    localparam logic [1:0] KIND_PBODY  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_HEADER_FORM = 1'b0;
    localparam logic CFG_LIST_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  density_code;
        logic [23:0] block_count;
        logic [23:0] block_size;
        logic [7:0]  byte_value;
        logic [7:0]  page_size;
        logic        page_end;
        logic        status;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/mode_select_list_parser_top.sv
// Top level of the mode select parameter list parser.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  mode, param_byte
//   out      output     out_valid/out_stall  result_kind .. last
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each accepted item is parsed in the cycle it is accepted and its zero, one
// or two results are written into a four-entry result queue, so one item is
// taken per clock. The output drains one result per clock; the input stalls
// only while the queue holds more than two results, which happens only when
// the output is stalled. Items that give two results end a list, so they can
// never follow each other back to back.
// Reset (rst_n low, asynchronous) empties the queue and puts the parser in
// its idle phase, where parameter bytes are ignored until a start item.
// cfg_ready is always high; the driver writes registers only while no item
// is in flight.
`default_nettype none

module mode_select_list_parser_top
    import mslp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel.
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  param_byte,
    // Output channel.
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [7:0]       density_code,
    output logic [23:0]      block_count,
    output logic [23:0]      block_size,
    output logic [7:0]       byte_value,
    output logic [7:0]       page_size,
    output logic             page_end,
    output logic             status,
    output logic             last,
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Parser phases.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_DESC   = 3'd2;
    localparam logic [2:0] PH_PCODE  = 3'd3;
    localparam logic [2:0] PH_PLEN   = 3'd4;
    localparam logic [2:0] PH_BODY   = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    // Configuration registers.
    logic        header_form_reg;
    logic [15:0] list_length_reg;

    // Parser state.
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [15:0] desc_left_reg, desc_left_next;
    logic [55:0] desc_shift_reg, desc_shift_next;
    logic [7:0]  page_code_reg, page_code_next;
    logic [7:0]  page_left_reg, page_left_next;
    logic        failed_reg, failed_next;

    // Result queue, entry 0 is the head.
    result_t               q_reg [QDEPTH];
    result_t               q_next [QDEPTH];
    logic [QCNT_W-1:0]     qcnt_reg, qcnt_next;

    logic     in_acc;
    logic     pop;
    logic     step_has;
    result_t  step_res;
    logic     fin_has;
    result_t  fin_res;
    result_t  res0, res1;
    logic     push0, push1;
    logic [QCNT_W-1:0] base;
    logic [15:0] eff_len;
    logic [2:0]  last_pos;
    logic [15:0] bl_dec;

    assign cfg_ready = 1'b1;
    assign in_stall  = (qcnt_reg > QCNT_W'(QDEPTH - 2));
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = (qcnt_reg != '0);
    assign pop       = out_valid && !out_stall;

    assign result_kind  = q_reg[0].result_kind;
    assign density_code = q_reg[0].density_code;
    assign block_count  = q_reg[0].block_count;
    assign block_size   = q_reg[0].block_size;
    assign byte_value   = q_reg[0].byte_value;
    assign page_size    = q_reg[0].page_size;
    assign page_end     = q_reg[0].page_end;
    assign status       = q_reg[0].status;
    assign last         = q_reg[0].last;

    assign eff_len  = (list_length_reg > BUFFER_BYTES) ? BUFFER_BYTES : list_length_reg;
    assign last_pos = header_form_reg ? 3'd7 : 3'd3;
    assign bl_dec   = bytes_left_reg - 16'd1;

    // Parse one item. At most one result comes from the phase itself and at
    // most one final status follows it.
    always_comb
    begin
        bytes_left_next   = bytes_left_reg;
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        desc_left_next    = desc_left_reg;
        desc_shift_next   = desc_shift_reg;
        page_code_next    = page_code_reg;
        page_left_next    = page_left_reg;
        failed_next       = failed_reg;
        step_has          = 1'b0;
        step_res          = '0;
        fin_has           = 1'b0;

        if (!mode)
        begin
            // Start of a new list.
            bytes_left_next   = eff_len;
            header_index_next = 3'd0;
            desc_left_next    = 16'd0;
            desc_shift_next   = 56'd0;
            page_code_next    = 8'd0;
            page_left_next    = 8'd0;
            failed_next       = 1'b0;
            phase_next        = PH_HEADER;
            if (eff_len == 16'd0)
            begin
                fin_has    = 1'b1;
                phase_next = PH_DONE;
            end
        end
        else if (phase_reg != PH_IDLE && phase_reg != PH_DONE)
        begin
            bytes_left_next = bl_dec;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_form_reg)
                    begin
                        if (header_index_reg == 3'd6)
                        begin
                            desc_left_next = {param_byte, 8'd0};
                        end
                        else if (header_index_reg == 3'd7)
                        begin
                            desc_left_next = {desc_left_reg[15:8], param_byte};
                        end
                    end
                    else if (header_index_reg == 3'd3)
                    begin
                        desc_left_next = {8'd0, param_byte};
                    end
                    if (header_index_reg == last_pos)
                    begin
                        if (desc_left_next > bl_dec || desc_left_next[2:0] != 3'd0)
                        begin
                            // Bad block descriptor length.
                            failed_next = 1'b1;
                            fin_has     = 1'b1;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            phase_next = (desc_left_next != 16'd0) ? PH_DESC : PH_PCODE;
                        end
                    end
                    header_index_next = header_index_reg + 3'd1;
                end
                PH_DESC:
                begin
                    desc_shift_next = {desc_shift_reg[47:0], param_byte};
                    desc_left_next  = desc_left_reg - 16'd1;
                    if (desc_left_next[2:0] == 3'd0)
                    begin
                        step_has              = 1'b1;
                        step_res.result_kind  = KIND_DESC;
                        step_res.density_code = desc_shift_reg[55:48];
                        step_res.block_count  = desc_shift_reg[47:24];
                        step_res.block_size   = {desc_shift_reg[15:0], param_byte};
                        desc_shift_next       = 56'd0;
                        if (desc_left_next == 16'd0)
                        begin
                            phase_next = PH_PCODE;
                        end
                    end
                end
                PH_PCODE:
                begin
                    page_code_next = param_byte;
                    phase_next     = PH_PLEN;
                end
                PH_PLEN:
                begin
                    if ({8'd0, param_byte} > bl_dec)
                    begin
                        // Page does not fit: drop it.
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        step_has             = 1'b1;
                        step_res.result_kind = KIND_PHDR;
                        step_res.byte_value  = page_code_reg;
                        step_res.page_size   = param_byte;
                        step_res.page_end    = (param_byte == 8'd0);
                        page_left_next       = param_byte;
                        phase_next           = (param_byte != 8'd0) ? PH_BODY : PH_PCODE;
                    end
                end
                PH_BODY:
                begin
                    page_left_next       = page_left_reg - 8'd1;
                    step_has             = 1'b1;
                    step_res.result_kind = KIND_PBODY;
                    step_res.byte_value  = param_byte;
                    step_res.page_end    = (page_left_next == 8'd0);
                    if (page_left_next == 8'd0)
                    begin
                        phase_next = PH_PCODE;
                    end
                end
                default:
                begin
                    // Skipping the rest of the list.
                end
            endcase
            if (phase_next != PH_DONE && bl_dec == 16'd0)
            begin
                if (phase_reg == PH_HEADER && phase_next == PH_HEADER)
                begin
                    // List ended inside the header.
                    failed_next = 1'b1;
                end
                fin_has    = 1'b1;
                phase_next = PH_DONE;
            end
        end
    end

    always_comb
    begin
        fin_res             = '0;
        fin_res.result_kind = KIND_STATUS;
        fin_res.status      = failed_next;
        fin_res.last        = 1'b1;

        res0      = step_has ? step_res : fin_res;
        res0.last = !(step_has && fin_has);
        res1      = fin_res;
        push0     = in_acc && (step_has || fin_has);
        push1     = in_acc && step_has && fin_has;
    end

    // Queue update: shift out the head on a pop, then append new results.
    always_comb
    begin
        base      = qcnt_reg - QCNT_W'(pop);
        qcnt_next = base + QCNT_W'(push0) + QCNT_W'(push1);
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && i < QDEPTH - 1)
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if (push0 && base[QIDX_W-1:0] == QIDX_W'(i))
            begin
                q_next[i] = res0;
            end
            if (push1 && QIDX_W'(base[QIDX_W-1:0] + QIDX_W'(1)) == QIDX_W'(i))
            begin
                q_next[i] = res1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_form_reg  <= 1'b0;
            list_length_reg  <= 16'd0;
            bytes_left_reg   <= 16'd0;
            phase_reg        <= PH_IDLE;
            header_index_reg <= 3'd0;
            desc_left_reg    <= 16'd0;
            desc_shift_reg   <= 56'd0;
            page_code_reg    <= 8'd0;
            page_left_reg    <= 8'd0;
            failed_reg       <= 1'b0;
            qcnt_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_HEADER_FORM: header_form_reg <= cfg_data[0];
                    CFG_LIST_LENGTH: list_length_reg <= cfg_data;
                    default:         list_length_reg <= list_length_reg;
                endcase
            end
            if (in_acc)
            begin
                bytes_left_reg   <= bytes_left_next;
                phase_reg        <= phase_next;
                header_index_reg <= header_index_next;
                desc_left_reg    <= desc_left_next;
                desc_shift_reg   <= desc_shift_next;
                page_code_reg    <= page_code_next;
                page_left_reg    <= page_left_next;
                failed_reg       <= failed_next;
            end
            qcnt_reg <= qcnt_next;
        end
    end

    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // A check condition is only ever left behind by a finished list.
    assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> phase_reg == PH_DONE)
        else $error("failed flag set outside the done phase");

    // With no item taken, a delivered result shrinks the queue by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !in_acc) |=> qcnt_reg == $past(qcnt_reg) - QCNT_W'(1))
        else $error("queue count wrong after pop");

    // A finished list stays finished until the next start item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !(in_acc && !mode)) |=> phase_reg == PH_DONE)
        else $error("left the done phase without a start item");

endmodule

`default_nettype wire

>>> tb/mode_select_list_parser_top_test.sv
// Self-checking testbench for the mode select parameter list parser: directed table, then random lists.
`timescale 1ns / 100ps

module mode_select_list_parser_top_test;
    import mslp_pkg::*;

    // Input items the random part sends that the parser actually parses.
    localparam int ITEMS = 500;
    // Percentage of cycles in which a side idles or stalls.
    localparam int IDLE_PCT = 34;
    // Cycles allowed after the last expected result before the block counts as idle.
    // Results are queued in the cycle after the item is taken, so the settle time covers
    // items that gave no result.
    localparam int SETTLE = 4;
    // Cycles with no item moving on any channel before the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    // Where the parser stands within the current parameter list.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_DESCRIPTORS,
        ST_PAGE_CODE,
        ST_PAGE_LENGTH,
        ST_PAGE_BODY,
        ST_SKIPPING,
        ST_FINISHED
    } parse_state_e;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

    // How a directed row is checked: by the predictor, or by a result typed in here.
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GOOD, EXP_CHECK} row_expect_e;

    // For an item row, sel is the mode and value[7:0] the byte; for a register row,
    // sel is the register index and value the write data.
    typedef struct {
        row_kind_e   kind;
        logic        sel;
        logic [15:0] value;
        row_expect_e how;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_START;
    logic [7:0]  param_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  density_code;
    logic [23:0] block_count;
    logic [23:0] block_size;
    logic [7:0]  byte_value;
    logic [7:0]  page_size;
    logic        page_end;
    logic        status;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_HEADER_FORM;
    logic [15:0] cfg_data = 16'h0000;

    // Shadow copy of the configuration registers, updated when a write is taken.
    logic        set_form = 1'b0;
    logic [15:0] set_length = 16'h0000;

    // Shadow copy of the parser state.
    parse_state_e parse_state = ST_IDLE;
    logic [15:0]  list_left = 16'h0000;
    logic [2:0]   hdr_pos = 3'd0;
    logic [15:0]  desc_left = 16'h0000;
    logic [55:0]  desc_acc = 56'h0;
    logic [7:0]   held_code = 8'h00;
    logic [7:0]   page_left = 8'h00;
    logic         list_failed = 1'b0;

    // Results that one item gives, as worked out by the predictor.
    result_t step_results[2];
    int      step_count;

    result_t     pending_results[$];
    stim_row_t   stim_rows[$];
    logic [7:0]  list_bytes[$];
    int          list_items = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    // When set, neither side idles; gives one long stretch at full rate.
    logic        calm = 1'b0;

    mode_select_list_parser_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .param_byte   (param_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .density_code (density_code),
        .block_count  (block_count),
        .block_size   (block_size),
        .byte_value   (byte_value),
        .page_size    (page_size),
        .page_end     (page_end),
        .status       (status),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The output side stalls at random, except during the calm stretch.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic string show(result_t r);
        return $sformatf("kind=%0d dens=%02h cnt=%06h size=%06h byte=%02h psize=%02h end=%0b st=%0b last=%0b",
                         r.result_kind, r.density_code, r.block_count, r.block_size,
                         r.byte_value, r.page_size, r.page_end, r.status, r.last);
    endfunction

    function automatic void add_row(row_kind_e kind, logic sel, logic [15:0] value,
                                    row_expect_e how);
        stim_rows.push_back('{kind, sel, value, how});
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] dens, input logic [23:0] cnt,
                        input logic [23:0] sz, input logic [7:0] bv, input logic [7:0] ps,
                        input logic pe, input logic st);
        result_t r;
        r = '0;
        r.result_kind = kind;
        r.density_code = dens;
        r.block_count = cnt;
        r.block_size = sz;
        r.byte_value = bv;
        r.page_size = ps;
        r.page_end = pe;
        r.status = st;
        step_results[step_count] = r;
        step_count++;
    endtask

    // The final status closes the list; nothing more is parsed until the next start.
    task automatic finish_list();
        parse_state = ST_FINISHED;
        emit(KIND_STATUS, 8'h00, 24'h0, 24'h0, 8'h00, 8'h00, 1'b0, list_failed);
    endtask

    // Works out the results of one accepted item and advances the shadow state.
    task automatic predict_parse(input logic m, input logic [7:0] b);
        logic [55:0] prev;
        step_count = 0;
        if (m == MODE_START)
        begin
            // The effective list length is the command's length clipped to the buffer.
            list_left = (set_length > BUFFER_BYTES) ? BUFFER_BYTES : set_length;
            hdr_pos = 3'd0;
            desc_left = 16'h0000;
            desc_acc = 56'h0;
            held_code = 8'h00;
            page_left = 8'h00;
            list_failed = 1'b0;
            parse_state = ST_HEADER;
            if (list_left == 16'h0000)
                finish_list();
        end
        else if (parse_state != ST_IDLE && parse_state != ST_FINISHED)
        begin
            list_left = list_left - 16'd1;
            case (parse_state)
                ST_HEADER:
                begin
                    // The header form is read on every byte, so a change in the middle
                    // of a header moves the position at which the header completes.
                    if (set_form)
                    begin
                        if (hdr_pos == 3'd6)
                            desc_left = {b, 8'h00};
                        else if (hdr_pos == 3'd7)
                            desc_left = desc_left | {8'h00, b};
                    end
                    else if (hdr_pos == 3'd3)
                    begin
                        desc_left = {8'h00, b};
                    end
                    if (hdr_pos == (set_form ? 3'd7 : 3'd3))
                    begin
                        if (desc_left > list_left || desc_left[2:0] != 3'd0)
                        begin
                            list_failed = 1'b1;
                            finish_list();
                        end
                        else
                        begin
                            parse_state = (desc_left != 16'h0000) ? ST_DESCRIPTORS : ST_PAGE_CODE;
                        end
                    end
                    hdr_pos = hdr_pos + 3'd1;
                end
                ST_DESCRIPTORS:
                begin
                    // Seven bytes are collected; the eighth completes the descriptor.
                    prev = desc_acc;
                    desc_acc = {prev[47:0], b};
                    desc_left = desc_left - 16'd1;
                    if (desc_left[2:0] == 3'd0)
                    begin
                        emit(KIND_DESC, prev[55:48], prev[47:24], {prev[15:0], b},
                             8'h00, 8'h00, 1'b0, 1'b0);
                        desc_acc = 56'h0;
                        if (desc_left == 16'h0000)
                            parse_state = ST_PAGE_CODE;
                    end
                end
                ST_PAGE_CODE:
                begin
                    held_code = b;
                    parse_state = ST_PAGE_LENGTH;
                end
                ST_PAGE_LENGTH:
                begin
                    // A page longer than what is left of the list is dropped silently.
                    if ({8'h00, b} > list_left)
                    begin
                        parse_state = ST_SKIPPING;
                    end
                    else
                    begin
                        emit(KIND_PHDR, 8'h00, 24'h0, 24'h0, held_code, b, b == 8'h00, 1'b0);
                        page_left = b;
                        parse_state = (b != 8'h00) ? ST_PAGE_BODY : ST_PAGE_CODE;
                    end
                end
                ST_PAGE_BODY:
                begin
                    page_left = page_left - 8'd1;
                    emit(KIND_PBODY, 8'h00, 24'h0, 24'h0, b, 8'h00, page_left == 8'h00, 1'b0);
                    if (page_left == 8'h00)
                        parse_state = ST_PAGE_CODE;
                end
                default:
                begin
                end
            endcase
            // Running out of bytes inside the header is a length error; anywhere else
            // the list simply ends with good status.
            if (parse_state != ST_FINISHED && list_left == 16'h0000)
            begin
                if (parse_state == ST_HEADER)
                    list_failed = 1'b1;
                finish_list();
            end
        end
        if (step_count > 0)
            step_results[step_count - 1].last = 1'b1;
    endtask

    // All driving tasks are entered and left just after a falling edge.
    task automatic send_item(input logic m, input logic [7:0] b, input row_expect_e how);
        result_t status_only;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        param_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // Only items the parser acts on count toward the random item budget.
        if (m == MODE_START || (parse_state != ST_IDLE && parse_state != ST_FINISHED))
            list_items++;
        predict_parse(m, b);
        case (how)
            EXP_MODEL:
            begin
                for (int k = 0; k < step_count; k++)
                    pending_results.push_back(step_results[k]);
            end
            EXP_GOOD, EXP_CHECK:
            begin
                status_only = '0;
                status_only.result_kind = KIND_STATUS;
                status_only.status = (how == EXP_CHECK);
                status_only.last = 1'b1;
                pending_results.push_back(status_only);
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
    endtask

    // Waits until every expected result has come out, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_HEADER_FORM)
            set_form = val[0];
        else
            set_length = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Builds a mostly well-formed parameter list for the current configuration:
    // header, a few block descriptors and pages that mostly fit, with the odd bad
    // descriptor length, oversized page, early cut or surplus bytes.
    task automatic build_list();
        int eff;
        int hdr;
        int room;
        int ndesc;
        int rem;
        int plen;
        int body;
        logic [15:0] dlen;
        eff = (set_length > BUFFER_BYTES) ? int'(BUFFER_BYTES) : int'(set_length);
        hdr = set_form ? 8 : 4;
        room = eff - hdr;
        ndesc = (room >= 8) ? int'($urandom_range(0, (room >= 16) ? 2 : 1)) : 0;
        dlen = 16'(ndesc * 8);
        if ($urandom_range(0, 9) == 0)
            dlen = 16'($urandom_range(0, 300));
        list_bytes.delete();
        for (int i = 0; i < hdr; i++)
        begin
            if (set_form && i == 6)
                list_bytes.push_back(dlen[15:8]);
            else if ((set_form && i == 7) || (!set_form && i == 3))
                list_bytes.push_back(dlen[7:0]);
            else
                list_bytes.push_back(rand_byte());
        end
        repeat (ndesc * 8)
            list_bytes.push_back(rand_byte());
        while (list_bytes.size() < eff)
        begin
            list_bytes.push_back(rand_byte());
            rem = eff - list_bytes.size();
            if (rem > 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    plen = $urandom_range(0, 255);
                else
                    plen = $urandom_range(0, (rem - 1 < 16) ? rem - 1 : 16);
                list_bytes.push_back(8'(plen));
                body = eff - list_bytes.size();
                if (plen < body)
                    body = plen;
                repeat (body)
                    list_bytes.push_back(rand_byte());
            end
        end
        case ($urandom_range(0, 9))
            0:
            begin
                if (list_bytes.size() > 0)
                    repeat ($urandom_range(1, list_bytes.size()))
                        void'(list_bytes.pop_back());
            end
            1:
            begin
                repeat ($urandom_range(1, 3))
                    list_bytes.push_back(rand_byte());
            end
            default:
            begin
            end
        endcase
    endtask

    // Each result taken from the output is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {result_kind, density_code, block_count, block_size, byte_value,
                    page_size, page_end, status, last};
            if (pending_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: result with nothing expected: %s", $realtime, show(seen));
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.result_kind !== want.result_kind
                    || seen.density_code !== want.density_code
                    || seen.block_count !== want.block_count
                    || seen.block_size !== want.block_size
                    || seen.byte_value !== want.byte_value
                    || seen.page_size !== want.page_size
                    || seen.page_end !== want.page_end
                    || seen.status !== want.status
                    || seen.last !== want.last)
                begin
                    if (fail_count < 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                 $realtime, show(want), show(seen));
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if no channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [15:0] len_pick;

        // A byte before any start is ignored; an empty list ends at once with good
        // status; a byte after the final status is ignored.
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_NONE);
        add_row(ROW_ITEM, MODE_START, 16'h0000, EXP_GOOD);
        add_row(ROW_ITEM, MODE_BYTE, 16'h005A, EXP_NONE);

        // The list ends inside the header.
        add_row(ROW_REG, CFG_LIST_LENGTH, 16'd2, EXP_NONE);
        add_row(ROW_ITEM, MODE_START, 16'h00A5, EXP_NONE);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_CHECK);

        // Descriptor length that is not a multiple of eight.
        add_row(ROW_REG, CFG_LIST_LENGTH, 16'd20, EXP_NONE);
        add_row(ROW_ITEM, MODE_START, 16'h0000, EXP_NONE);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0004, EXP_CHECK);

        // Full list: one descriptor with extreme fields, an empty page, and a
        // one-byte page whose body byte also ends the list (two results at once).
        add_row(ROW_REG, CFG_LIST_LENGTH, 16'd17, EXP_NONE);
        add_row(ROW_ITEM, MODE_START, 16'h0000, EXP_NONE);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0008, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h00FF, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h003F, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0080, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0001, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);

        // Header form switched from eight-byte to four-byte in the middle of the
        // header, then a page too long for the rest of the list, skipped to the end.
        add_row(ROW_REG, CFG_HEADER_FORM, 16'd1, EXP_NONE);
        add_row(ROW_REG, CFG_LIST_LENGTH, 16'd7, EXP_NONE);
        add_row(ROW_ITEM, MODE_START, 16'h0000, EXP_NONE);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0011, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0022, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0033, EXP_MODEL);
        add_row(ROW_REG, CFG_HEADER_FORM, 16'd0, EXP_NONE);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0001, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0002, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0055, EXP_GOOD);

        // A lone page code byte at the end of the list still ends with good status.
        add_row(ROW_REG, CFG_LIST_LENGTH, 16'd5, EXP_NONE);
        add_row(ROW_ITEM, MODE_START, 16'h0000, EXP_NONE);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h0000, EXP_MODEL);
        add_row(ROW_ITEM, MODE_BYTE, 16'h007F, EXP_GOOD);

        // Reset is held low, then released on a falling edge.
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_REG)
                write_reg(stim_rows[k].sel, stim_rows[k].value);
            else
                send_item(stim_rows[k].sel, stim_rows[k].value[7:0], stim_rows[k].how);
        end

        // Random part: each round sets both registers, then sends one to three
        // lists or short bursts of noise. Noise bytes without a start continue
        // whatever list a previous round left unfinished.
        list_items = 0;
        while (list_items < ITEMS)
        begin
            calm <= (list_items >= 200 && list_items < 300);
            case ($urandom_range(0, 39))
                0: len_pick = 16'h0000;
                1: len_pick = 16'hFFFF;
                2: len_pick = 16'($urandom_range(257, 65534));
                3: len_pick = BUFFER_BYTES;
                default: len_pick = 16'($urandom_range(1, 40));
            endcase
            write_reg(CFG_HEADER_FORM, 16'($urandom_range(0, 1)));
            write_reg(CFG_LIST_LENGTH, len_pick);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        send_item(($urandom_range(0, 7) != 0) ? MODE_BYTE : MODE_START,
                                  rand_byte(), EXP_MODEL);
                end
                else
                begin
                    build_list();
                    send_item(MODE_START, rand_byte(), EXP_MODEL);
                    foreach (list_bytes[j])
                        send_item(MODE_BYTE, list_bytes[j], EXP_MODEL);
                end
            end
        end

        drain();
        repeat (2 * SETTLE)
            @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
